// File: hdl/sdzm_pkg.sv
// ----------------------------------------------------------------------------
// sdzm_pkg
// Shared register indexes, reset values and widths of the radial deadzone map.
// ----------------------------------------------------------------------------
package sdzm_pkg;

  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int RAD_W   = 12;
  localparam int FRAC_W  = 16;
  localparam int AXIS_W  = 16;
  localparam int OUT_W   = 40;

  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_STICK_RADIUS  = 2'd0;
  localparam cfg_idx_t REG_DEADZONE_FRAC = 2'd1;
  localparam cfg_idx_t REG_FULL_FRAC     = 2'd2;

  localparam logic [RAD_W-1:0]  RADIUS_RST   = 12'd128;
  localparam logic [FRAC_W-1:0] DEADZONE_RST = 16'd7864;
  localparam logic [FRAC_W-1:0] FULL_RST     = 16'd55706;

  localparam logic [AXIS_W-1:0] AXIS_MAX = 16'd32767;

endpackage

// File: hdl/sdzm_isqrt.sv
// ----------------------------------------------------------------------------
// sdzm_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module sdzm_isqrt #(
  parameter int RW = 24,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] radicand,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   out_side
);
  import sdzm_pkg::*;

  logic [2*RW-1:0] v_in    [RW];
  logic [RW+1:0]   rem_in  [RW];
  logic [RW-1:0]   root_in [RW];
  logic [SW-1:0]   side_in [RW];
  logic            vld_in  [RW];

  logic [2*RW-1:0] v_r    [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SW-1:0]   side_r [RW];
  logic            vld_r  [RW];

  assign v_in[0]    = radicand;
  assign rem_in[0]  = '0;
  assign root_in[0] = '0;
  assign side_in[0] = in_side;
  assign vld_in[0]  = in_valid;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int I = RW - 1 - j;
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic          ge;

    if (j > 0) begin : g_link
      assign v_in[j]    = v_r[j-1];
      assign rem_in[j]  = rem_r[j-1];
      assign root_in[j] = root_r[j-1];
      assign side_in[j] = side_r[j-1];
      assign vld_in[j]  = vld_r[j-1];
    end

    always_comb begin
      t     = {rem_in[j][RW-1:0], v_in[j][2*I+1 -: 2]};
      trial = {root_in[j], 2'b01};
      ge    = (t >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[j]    <= v_in[j];
        rem_r[j]  <= ge ? (t - trial) : t;
        root_r[j] <= {root_in[j][RW-2:0], ge};
        side_r[j] <= side_in[j];
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root      = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

// File: hdl/sdzm_div.sv
// ----------------------------------------------------------------------------
// sdzm_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sdzm_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] out_side
);
  import sdzm_pkg::*;

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_in  [QW];
  logic [DW-1:0] den_in  [QW];
  logic [QW-1:0] q_in    [QW];
  logic [SW-1:0] side_in [QW];
  logic          vld_in  [QW];

  logic [W-1:0]  rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [SW-1:0] side_r [QW];
  logic          vld_r  [QW];

  assign rem_in[0]  = W'(num);
  assign den_in[0]  = den;
  assign q_in[0]    = '0;
  assign side_in[0] = in_side;
  assign vld_in[0]  = in_valid;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [W-1:0] sh;
    logic         ge;

    if (j > 0) begin : g_link
      assign rem_in[j]  = rem_r[j-1];
      assign den_in[j]  = den_r[j-1];
      assign q_in[j]    = q_r[j-1];
      assign side_in[j] = side_r[j-1];
      assign vld_in[j]  = vld_r[j-1];
    end

    always_comb begin
      sh = W'(den_in[j]) << K;
      ge = (rem_in[j] >= sh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? (rem_in[j] - sh) : rem_in[j];
        den_r[j]  <= den_in[j];
        q_r[j]    <= q_in[j] | (QW'(ge) << K);
        side_r[j] <= side_in[j];
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quot      = q_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// File: hdl/stick_radial_deadzone_map_unit.sv
// ----------------------------------------------------------------------------
// stick_radial_deadzone_map_unit
// Maps a touch stick sample to two signed axes with a scaled radial deadzone.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while the output is not stalled and
// delivers one result word per input word, in order. The pipeline holds the
// bit-per-stage square root, the magnitude divider, the 16-stage
// rescale divider and the 16-stage axis dividers. A stall on the output
// holds the whole pipeline.
module stick_radial_deadzone_map_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic                         cfg_we,
  input  sdzm_pkg::cfg_idx_t           cfg_index,
  input  logic [sdzm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // active, touch_x, touch_y, center_x, center_y, zero fill
  input  logic [((4*COORD_BITS+8)/8)*8-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // thumb_x, thumb_y, in_deadzone, zero fill
  output logic [sdzm_pkg::OUT_W-1:0]   m_axis_tdata
);
  import sdzm_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int RW  = C + 8;
  localparam int MW  = C + 17;
  localparam int PW  = C + 17;
  localparam int NW  = C + 33;
  localparam int S1W = 3 + 2 * C;
  localparam int S2W = S1W + RW;
  localparam int S3W = 2 + 2 + 2 * C + RW;

  logic [RAD_W-1:0]  stick_radius;
  logic [FRAC_W-1:0] deadzone_frac;
  logic [FRAC_W-1:0] full_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_radius  <= RADIUS_RST;
      deadzone_frac <= DEADZONE_RST;
      full_frac     <= FULL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STICK_RADIUS:  stick_radius  <= cfg_data[RAD_W-1:0];
        REG_DEADZONE_FRAC: deadzone_frac <= cfg_data[FRAC_W-1:0];
        REG_FULL_FRAC:     full_frac     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic         in_active;
  logic [C:0]   dx;
  logic [C:0]   dy;
  logic [C-1:0] ax_c;
  logic [C-1:0] ay_c;

  always_comb begin
    in_active = s_axis_tdata[0];
    dx   = {1'b0, s_axis_tdata[C:1]} - {1'b0, s_axis_tdata[3*C:2*C+1]};
    dy   = {1'b0, s_axis_tdata[4*C:3*C+1]} - {1'b0, s_axis_tdata[2*C:C+1]};
    ax_c = dx[C] ? C'(-dx) : dx[C-1:0];
    ay_c = dy[C] ? C'(-dy) : dy[C-1:0];
  end

  logic         v0, kill0, sx0, sy0;
  logic [C-1:0] ax0, ay0;
  logic         v1, kill1, sx1, sy1;
  logic [C-1:0] ax1, ay1;
  logic [2*C-1:0] sqx1, sqy1;
  logic         v2, kill2, sx2, sy2;
  logic [C-1:0] ax2, ay2;
  logic [2*C:0] d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kill0 <= !in_active || (stick_radius == '0);
      sx0   <= dx[C];
      sy0   <= dy[C];
      ax0   <= ax_c;
      ay0   <= ay_c;
      kill1 <= kill0;
      sx1   <= sx0;
      sy1   <= sy0;
      ax1   <= ax0;
      ay1   <= ay0;
      sqx1  <= ax0 * ax0;
      sqy1  <= ay0 * ay0;
      kill2 <= kill1;
      sx2   <= sx1;
      sy2   <= sy1;
      ax2   <= ax1;
      ay2   <= ay1;
      d2    <= {1'b0, sqx1} + {1'b0, sqy1};
    end
  end

  logic           sq_valid;
  logic [RW-1:0]  dist7;
  logic [S1W-1:0] sq_side;

  sdzm_isqrt #(.RW(RW), .SW(S1W)) u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2),
    .radicand((2*RW)'({d2, 14'b0})),
    .in_side({kill2, sx2, sy2, ax2, ay2}),
    .out_valid(sq_valid),
    .root(dist7),
    .out_side(sq_side)
  );

  logic           mg_valid;
  logic [MW-1:0]  mag16;
  logic [S2W-1:0] mg_side;

  sdzm_div #(.NW(MW), .DW(RAD_W), .QW(MW), .SW(S2W)) u_mag_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sq_valid),
    .num({dist7, 9'b0}),
    .den(stick_radius),
    .in_side({sq_side, dist7}),
    .out_valid(mg_valid),
    .quot(mag16),
    .out_side(mg_side)
  );

  logic          mg_kill, mg_sx, mg_sy;
  logic [C-1:0]  mg_ax, mg_ay;
  logic [RW-1:0] mg_dist;
  logic [FRAC_W-1:0] span;
  logic [MW-1:0] above;
  logic          dz_c, full_c;

  always_comb begin
    {mg_kill, mg_sx, mg_sy, mg_ax, mg_ay, mg_dist} = mg_side;
    span   = full_frac - deadzone_frac;
    above  = mag16 - MW'(deadzone_frac);
    dz_c   = mg_kill || (mag16 <= MW'(deadzone_frac));
    full_c = (full_frac <= deadzone_frac) || (above >= MW'(span));
  end

  logic              v3, dz3, full3, sx3, sy3;
  logic [C-1:0]      ax3, ay3;
  logic [RW-1:0]     dist3;
  logic [FRAC_W-1:0] diff3, span3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= mg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz3   <= dz_c;
      full3 <= full_c;
      sx3   <= mg_sx;
      sy3   <= mg_sy;
      ax3   <= mg_ax;
      ay3   <= mg_ay;
      dist3 <= mg_dist;
      diff3 <= above[FRAC_W-1:0];
      span3 <= span;
    end
  end

  logic              sc_valid;
  logic [FRAC_W-1:0] sc_q;
  logic [S3W-1:0]    sc_side;

  sdzm_div #(.NW(2*FRAC_W), .DW(FRAC_W), .QW(FRAC_W), .SW(S3W)) u_scale_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3),
    .num({diff3, 16'b0}),
    .den(span3),
    .in_side({dz3, full3, sx3, sy3, ax3, ay3, dist3}),
    .out_valid(sc_valid),
    .quot(sc_q),
    .out_side(sc_side)
  );

  logic          sc_dz, sc_full, sc_sx, sc_sy;
  logic [C-1:0]  sc_ax, sc_ay;
  logic [RW-1:0] sc_dist;
  logic [16:0]   scaled;

  always_comb begin
    {sc_dz, sc_full, sc_sx, sc_sy, sc_ax, sc_ay, sc_dist} = sc_side;
    scaled = sc_full ? 17'h10000 : {1'b0, sc_q};
  end

  logic          v4, dz4, sx4, sy4;
  logic [RW-1:0] dist4;
  logic [PW-1:0] px4, py4;
  logic          v5, dz5, sx5, sy5;
  logic [NW-1:0] nx5, ny5;
  logic [MW-1:0] den5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= sc_valid;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz4   <= sc_dz;
      sx4   <= sc_sx;
      sy4   <= sc_sy;
      dist4 <= sc_dist;
      px4   <= sc_ax * scaled;
      py4   <= sc_ay * scaled;
      dz5   <= dz4;
      sx5   <= sx4;
      sy5   <= sy4;
      nx5   <= (NW'(px4) << 15) - NW'(px4) + (NW'(dist4) << 8);
      ny5   <= (NW'(py4) << 15) - NW'(py4) + (NW'(dist4) << 8);
      den5  <= {dist4, 9'b0};
    end
  end

  logic              ax_valid, ay_valid_unused;
  logic [AXIS_W-1:0] qx, qy;
  logic [2:0]        ax_side;
  logic              ay_side_unused;

  sdzm_div #(.NW(NW), .DW(MW), .QW(AXIS_W), .SW(3)) u_axis_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5),
    .num(nx5),
    .den(den5),
    .in_side({dz5, sx5, sy5}),
    .out_valid(ax_valid),
    .quot(qx),
    .out_side(ax_side)
  );

  sdzm_div #(.NW(NW), .DW(MW), .QW(AXIS_W), .SW(1)) u_axis_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5),
    .num(ny5),
    .den(den5),
    .in_side(1'b0),
    .out_valid(ay_valid_unused),
    .quot(qy),
    .out_side(ay_side_unused)
  );

  logic [AXIS_W-1:0] capx, capy, thx, thy;

  always_comb begin
    capx = (qx > AXIS_MAX) ? AXIS_MAX : qx;
    capy = (qy > AXIS_MAX) ? AXIS_MAX : qy;
    thx  = ax_side[2] ? '0 : (ax_side[1] ? -capx : capx);
    thy  = ax_side[2] ? '0 : (ax_side[0] ? -capy : capy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= ax_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OUT_W'({ax_side[2], thy, thx});
    end
  end

endmodule

// File: hdl/sdzm_checker.sv
// ----------------------------------------------------------------------------
// sdzm_checker
// Port-level checks on the result stream of the radial deadzone map.
// ----------------------------------------------------------------------------
module sdzm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sdzm_pkg::OUT_W-1:0] m_axis_tdata
);
  import sdzm_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  a_centered: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("deadzone word with nonzero axes");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000)
    else $error("axis value out of range");

endmodule

bind stick_radial_deadzone_map_unit sdzm_checker u_sdzm_checker (.*);

// File: bench/stick_radial_deadzone_map_unit_tb.sv
// ----------------------------------------------------------------------------
// stick_radial_deadzone_map_unit_tb
// Drives touch stick samples through the deadzone map under several register
// settings and random stalls on both sides, and compares every result word
// with a fixed-point prediction of the thumb axes and the deadzone flag.
// ----------------------------------------------------------------------------
module stick_radial_deadzone_map_unit_tb;
  import sdzm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int IN_W = ((4*CB+8)/8)*8;

  typedef struct packed {
    logic        in_deadzone;
    logic [15:0] thumb_y;
    logic [15:0] thumb_x;
  } thumb_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  cfg_idx_t cfg_index = REG_STICK_RADIUS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;

  longint unsigned radius_q, dz_q, full_q;
  thumb_t expected_thumbs[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit failed = 0;

  stick_radial_deadzone_map_unit #(.COORD_BITS(CB)) dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] axis_of(longint d, longint unsigned sc,
                                          longint unsigned d7);
    longint unsigned a, num, den, q;
    a = (d < 0) ? -d : d;
    num = (a << 7) * sc * 32767;
    den = d7 << 16;
    q = (2 * num + den) / (2 * den);
    if (q > 32767) q = 32767;
    if (d < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic thumb_t map_stick(logic act, logic [15:0] tx, logic [15:0] ty,
                                       logic [15:0] ox, logic [15:0] oy);
    thumb_t r;
    longint dx, dy;
    longint unsigned d7, mag, sc;
    r = '{1'b1, 16'd0, 16'd0};
    if (!act || radius_q == 0) return r;
    dx = longint'(tx) - longint'(ox);
    dy = longint'(oy) - longint'(ty);
    d7 = isqrt((dx * dx + dy * dy) << 14);
    mag = (d7 << 9) / radius_q;
    if (mag <= dz_q) return r;
    if (full_q <= dz_q) sc = 65536;
    else begin
      sc = ((mag - dz_q) << 16) / (full_q - dz_q);
      if (sc > 65536) sc = 65536;
    end
    r.thumb_x = axis_of(dx, sc, d7);
    r.thumb_y = axis_of(dy, sc, d7);
    r.in_deadzone = 1'b0;
    return r;
  endfunction

  task automatic send_sample(logic act, logic [15:0] tx, logic [15:0] ty,
                             logic [15:0] ox, logic [15:0] oy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, oy, ox, ty, tx, act};
    expected_thumbs.insert(expected_thumbs.size(), map_stick(act, tx, ty, ox, oy));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_thumbs.size() != 0) @(posedge clk);
    repeat (2 * CB + 80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_STICK_RADIUS: radius_q = 64'(val[11:0]);
      REG_DEADZONE_FRAC: dz_q = 64'(val);
      REG_FULL_FRAC: full_q = 64'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [11:0] r, logic [15:0] d, logic [15:0] f);
    drain();
    write_reg(REG_STICK_RADIUS, {4'd0, r});
    write_reg(REG_DEADZONE_FRAC, d);
    write_reg(REG_FULL_FRAC, f);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    send_sample(0, 16'd500, 16'd500, 16'd100, 16'd100);
    send_sample(1, 16'd100, 16'd100, 16'd100, 16'd100);
    send_sample(1, 16'd110, 16'd100, 16'd100, 16'd100);
    send_sample(1, 16'd300, 16'd100, 16'd100, 16'd100);
    send_sample(1, 16'd0, 16'd100, 16'd100, 16'd100);
    send_sample(1, 16'd100, 16'd0, 16'd100, 16'd100);
    send_sample(1, 16'd100, 16'd250, 16'd100, 16'd100);
    send_sample(1, 16'd180, 16'd20, 16'd100, 16'd100);
    send_sample(1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_sample(1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_sample(1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_sample(1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_sample(1, 16'd200, 16'd100, 16'd100, 16'd100);
    send_sample(1, 16'd209, 16'd100, 16'd100, 16'd100);
  endtask

  task automatic test_random(int n);
    logic [15:0] ox, oy, tx, ty;
    int span;
    repeat (n) begin
      ox = 16'($urandom);
      oy = 16'($urandom);
      span = (radius_q == 0) ? 256 : int'(2 * radius_q);
      case ($urandom_range(3))
        0: begin
          tx = 16'($urandom);
          ty = 16'($urandom);
        end
        default: begin
          tx = 16'(int'(ox) + int'($urandom_range(2 * span)) - span);
          ty = 16'(int'(oy) + int'($urandom_range(2 * span)) - span);
        end
      endcase
      send_sample($urandom_range(9) != 0, tx, ty, ox, oy);
    end
  endtask

  task automatic test_settings(int n);
    set_regs(12'd1, 16'd0, 16'd1);
    test_random(n);
    set_regs(12'd4095, 16'd65535, 16'd65535);
    test_directed();
    test_random(n);
    set_regs(12'd0, 16'd100, 16'd200);
    test_random(8);
    set_regs(12'd200, 16'd30000, 16'd10000);
    test_random(n);
    set_regs(12'd64, 16'd0, 16'd65535);
    test_random(n);
    set_regs(12'd128, 16'd7864, 16'd55706);
  endtask

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    thumb_t got, exp_t;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[32:0];
      if (expected_thumbs.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata);
        failed = 1;
      end else begin
        exp_t = expected_thumbs.pop_front();
        if (got.thumb_x !== exp_t.thumb_x) begin
          $error("thumb_x expected %0d actual %0d", $signed(exp_t.thumb_x),
                 $signed(got.thumb_x));
          failed = 1;
        end
        if (got.thumb_y !== exp_t.thumb_y) begin
          $error("thumb_y expected %0d actual %0d", $signed(exp_t.thumb_y),
                 $signed(got.thumb_y));
          failed = 1;
        end
        if (got.in_deadzone !== exp_t.in_deadzone) begin
          $error("in_deadzone expected %0b actual %0b", exp_t.in_deadzone,
                 got.in_deadzone);
          failed = 1;
        end
      end
    end
  end

  initial begin
    radius_q = 64'(RADIUS_RST);
    dz_q = 64'(DEADZONE_RST);
    full_q = 64'(FULL_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 31;
    recv_idle_pct = 85;
    test_random(60);
    test_settings(30);
    send_idle_pct = 85;
    recv_idle_pct = 31;
    test_random(60);
    test_settings(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(120);
    drain();
    if (!failed && expected_thumbs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
hdl/sdzm_pkg.sv
hdl/sdzm_isqrt.sv
hdl/sdzm_div.sv
hdl/stick_radial_deadzone_map_unit.sv
hdl/sdzm_checker.sv
bench/stick_radial_deadzone_map_unit_tb.sv
